>>> rtl/aqu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqu_pkg
// Types, constants and helper functions for the attitude quaternion update.
// ----------------------------------------------------------------------------
package aqu_pkg;

	localparam int RSQRT_ITER_DEF = 3;

	localparam logic [31:0] Q30_ONE        = 32'd1073741824;
	localparam logic [31:0] Q31_ONE        = 32'h8000_0000;
	localparam logic [31:0] CHORD_MID      = 32'd759250125;
	localparam logic [31:0] CHORD_SLOPE_LO = 32'd314491699;
	localparam logic [31:0] CHORD_SLOPE_HI = 32'd111189713;
	localparam logic [16:0] TRUST_ONE      = 17'd65536;
	localparam logic [16:0] KP_FLOOR_Q16   = 17'd6554;
	localparam logic [16:0] KP_SPAN_Q16    = 17'd58982;

	localparam logic [23:0] PROP_GAIN_RST  = 24'd65536;
	localparam logic [23:0] INT_GAIN_RST   = 24'd655;
	localparam logic [23:0] GRAVITY_RST    = 24'd642689;
	localparam logic [23:0] DEV_SCALE_RST  = 24'd44552;

	typedef enum logic [2:0] {
		CFG_PROP_GAIN,
		CFG_INTEGRAL_GAIN,
		CFG_DYN_ENABLE,
		CFG_GRAVITY_REF,
		CFG_DEV_SCALE,
		CFG_BIAS_X,
		CFG_BIAS_Y,
		CFG_BIAS_Z
	} cfg_reg_t;

	// Linear order matters: the sequencer steps to the next member by default.
	typedef enum logic [6:0] {
		U_IDLE,
		U_ASQ0, U_ASQ1, U_ASQ2, U_ACHK,
		U_TRM, U_TRD, U_TRK, U_TRP,
		U_AN0, U_AN1, U_AN2,
		U_V0A, U_V0B, U_V1A, U_V1B, U_V2A, U_V2B, U_V2C, U_V2D,
		U_E0A, U_E0B, U_E1A, U_E1B, U_E2A, U_E2B,
		U_I0, U_I1, U_I2,
		U_G0K, U_G0I, U_G1K, U_G1I, U_G2K, U_G2I,
		U_TH0, U_TH1, U_TH2,
		U_Q0A, U_Q0B, U_Q0C, U_Q1A, U_Q1B, U_Q1C,
		U_Q2A, U_Q2B, U_Q2C, U_Q3A, U_Q3B, U_Q3C,
		U_N0, U_N1, U_N2, U_N3, U_NCHK,
		U_AT0, U_AT1, U_AT2, U_AT3,
		U_DONE,
		U_NORM, U_CH, U_NY, U_NU, U_ND
	} uop_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647)
			return 32'sh7fff_ffff;
		else if (v < -68'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [67:0] sx32(input logic signed [31:0] v);
		return 68'(v);
	endfunction

endpackage

>>> rtl/ahrs_quaternion_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahrs_quaternion_update
// Complementary-filter attitude update: one IMU sample in, one quaternion out.
// ----------------------------------------------------------------------------
// Every product is formed on the shared 33x33 multiplier, and each reciprocal
// square root adds a normalize loop; when the acceleration is near zero the
// correction is skipped. One sample in flight: the next can be taken in the
// cycle after the result is loaded, later if the previous result still waits.
// Reset: identity attitude, zero integral and trust, registers at defaults.
module ahrs_quaternion_update
	import aqu_pkg::*;
#(
	parameter int RSQRT_ITERATIONS = RSQRT_ITER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [31:0] accel_x,
	input  logic signed [31:0] accel_y,
	input  logic signed [31:0] accel_z,
	input  logic signed [31:0] gyro_x,
	input  logic signed [31:0] gyro_y,
	input  logic signed [31:0] gyro_z,
	input  logic        [31:0] time_step,
	output logic               quat_valid,
	input  logic               quat_stall,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic        [16:0] accel_trust,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data
);

	localparam int ProdW = 66;
	localparam int AccW  = 68;
	localparam int IterW = $clog2(RSQRT_ITERATIONS + 1);

	// control
	uop_t             uop_q, uop_nxt;
	logic             ph_q, adv, has_mul, last_iter;
	logic [IterW-1:0] it_q;
	logic             rs_sel_q;
	logic             quat_valid_q;

	// configuration
	logic        [23:0] prop_gain_q, integral_gain_q, gravity_ref_q, deviation_scale_q;
	logic               dyn_enable_q;
	logic signed [31:0] bias_x_q, bias_y_q, bias_z_q;

	// filter state
	logic signed [31:0] att0_q, att1_q, att2_q, att3_q;
	logic signed [31:0] ei0_q, ei1_q, ei2_q;
	logic        [16:0] trust_q;

	// working registers
	logic signed [32:0]      mul_a, mul_b;
	logic signed [ProdW-1:0] prod_q;
	logic signed [AccW-1:0]  prod_x, p16, p19, p24, p30, p31, p38, ph;
	logic signed [AccW-1:0]  acc_q;
	logic signed [31:0]      ax_q, ay_q, az_q;
	logic        [31:0]      dt_q;
	logic signed [35:0]      g0_q, g1_q, g2_q;
	logic        [63:0]      x_q;
	logic        [4:0]       k_q, h_q;
	logic        [31:0]      m_q, y_q, t_q, d_q, dev_q;
	logic        [16:0]      kf_q;
	logic        [23:0]      kp_q;
	logic signed [31:0]      an0_q, an1_q, an2_q, v0_q, v1_q, v2_q, e0_q, e1_q, e2_q;
	logic signed [31:0]      th0_q, th1_q, th2_q, qn0_q, qn1_q, qn2_q, qn3_q;
	logic signed [31:0]      quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic        [16:0]      trust_out_q;
	logic        [31:0]      sm;
	logic        [32:0]      norm, dev;

	assign prod_x = {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
	assign p16 = prod_x >>> 16;
	assign p19 = prod_x >>> 19;
	assign p24 = prod_x >>> 24;
	assign p30 = prod_x >>> 30;
	assign p31 = prod_x >>> 31;
	assign p38 = prod_x >>> 38;
	assign ph  = prod_x >>> h_q;

	assign last_iter = (it_q == IterW'(RSQRT_ITERATIONS - 1));

	// magnitude from m*y, rescaled by the exponent, and its distance to gravity
	always_comb begin
		sm = p30[31:0];
		if (h_q == 5'd31)
			norm = {sm, 1'b0};
		else
			norm = {1'b0, sm} >> (5'd30 - h_q);
		if (norm > 33'(gravity_ref_q))
			dev = norm - 33'(gravity_ref_q);
		else
			dev = 33'(gravity_ref_q) - norm;
	end

	// next state
	always_comb begin
		uop_nxt = uop_t'(uop_q + 7'd1);
		adv = !has_mul || ph_q;
		unique case (uop_q)
			U_IDLE: adv = sample_valid;
			U_ACHK: uop_nxt = (acc_q > 68'sd4294) ? U_NORM : U_TH0;
			U_NORM: uop_nxt = (x_q[63:62] != 2'b00) ? U_CH : U_NORM;
			U_ND: begin
				if (!last_iter)
					uop_nxt = U_NY;
				else if (rs_sel_q)
					uop_nxt = U_AT0;
				else if (dyn_enable_q)
					uop_nxt = U_TRM;
				else
					uop_nxt = U_AN0;
			end
			U_NCHK: uop_nxt = (acc_q[63:0] == 64'd0) ? U_DONE : U_NORM;
			U_DONE: begin
				adv = !quat_valid_q || !quat_stall;
				uop_nxt = U_IDLE;
			end
			default: ;
		endcase
	end

	// outputs: multiplier operands
	always_comb begin
		has_mul = 1'b1;
		mul_a = '0;
		mul_b = '0;
		unique case (uop_q)
			U_ASQ0: begin mul_a = 33'(ax_q); mul_b = 33'(ax_q); end
			U_ASQ1: begin mul_a = 33'(ay_q); mul_b = 33'(ay_q); end
			U_ASQ2: begin mul_a = 33'(az_q); mul_b = 33'(az_q); end
			U_CH: begin
				if (!m_q[31]) begin
					mul_a = 33'(m_q - Q30_ONE);
					mul_b = 33'(CHORD_SLOPE_LO);
				end else begin
					mul_a = 33'(m_q - Q31_ONE);
					mul_b = 33'(CHORD_SLOPE_HI);
				end
			end
			U_NY:  begin mul_a = 33'(y_q); mul_b = 33'(y_q); end
			U_NU:  begin mul_a = 33'(m_q); mul_b = 33'(t_q); end
			U_ND:  begin mul_a = 33'(y_q); mul_b = 33'(d_q); end
			U_TRM: begin mul_a = 33'(m_q); mul_b = 33'(y_q); end
			U_TRD: begin mul_a = 33'(dev_q); mul_b = 33'(deviation_scale_q); end
			U_TRK: begin mul_a = 33'(KP_SPAN_Q16); mul_b = 33'(trust_q); end
			U_TRP: begin mul_a = 33'(prop_gain_q); mul_b = 33'(kf_q); end
			U_AN0: begin mul_a = 33'(ax_q); mul_b = 33'(y_q); end
			U_AN1: begin mul_a = 33'(ay_q); mul_b = 33'(y_q); end
			U_AN2: begin mul_a = 33'(az_q); mul_b = 33'(y_q); end
			U_V0A: begin mul_a = 33'(att1_q); mul_b = 33'(att3_q); end
			U_V0B: begin mul_a = 33'(att0_q); mul_b = 33'(att2_q); end
			U_V1A: begin mul_a = 33'(att0_q); mul_b = 33'(att1_q); end
			U_V1B: begin mul_a = 33'(att2_q); mul_b = 33'(att3_q); end
			U_V2A: begin mul_a = 33'(att0_q); mul_b = 33'(att0_q); end
			U_V2B: begin mul_a = 33'(att1_q); mul_b = 33'(att1_q); end
			U_V2C: begin mul_a = 33'(att2_q); mul_b = 33'(att2_q); end
			U_V2D: begin mul_a = 33'(att3_q); mul_b = 33'(att3_q); end
			U_E0A: begin mul_a = 33'(an1_q); mul_b = 33'(v2_q); end
			U_E0B: begin mul_a = 33'(an2_q); mul_b = 33'(v1_q); end
			U_E1A: begin mul_a = 33'(an2_q); mul_b = 33'(v0_q); end
			U_E1B: begin mul_a = 33'(an0_q); mul_b = 33'(v2_q); end
			U_E2A: begin mul_a = 33'(an0_q); mul_b = 33'(v1_q); end
			U_E2B: begin mul_a = 33'(an1_q); mul_b = 33'(v0_q); end
			U_I0:  begin mul_a = 33'(e0_q); mul_b = 33'(dt_q); end
			U_I1:  begin mul_a = 33'(e1_q); mul_b = 33'(dt_q); end
			U_I2:  begin mul_a = 33'(e2_q); mul_b = 33'(dt_q); end
			U_G0K: begin mul_a = 33'(kp_q); mul_b = 33'(e0_q); end
			U_G0I: begin mul_a = 33'(integral_gain_q); mul_b = 33'(ei0_q); end
			U_G1K: begin mul_a = 33'(kp_q); mul_b = 33'(e1_q); end
			U_G1I: begin mul_a = 33'(integral_gain_q); mul_b = 33'(ei1_q); end
			U_G2K: begin mul_a = 33'(kp_q); mul_b = 33'(e2_q); end
			U_G2I: begin mul_a = 33'(integral_gain_q); mul_b = 33'(ei2_q); end
			U_TH0: begin mul_a = 33'(sat32(68'(g0_q))); mul_b = 33'(dt_q); end
			U_TH1: begin mul_a = 33'(sat32(68'(g1_q))); mul_b = 33'(dt_q); end
			U_TH2: begin mul_a = 33'(sat32(68'(g2_q))); mul_b = 33'(dt_q); end
			U_Q0A: begin mul_a = 33'(att1_q); mul_b = 33'(th0_q); end
			U_Q0B: begin mul_a = 33'(att2_q); mul_b = 33'(th1_q); end
			U_Q0C: begin mul_a = 33'(att3_q); mul_b = 33'(th2_q); end
			U_Q1A: begin mul_a = 33'(att0_q); mul_b = 33'(th0_q); end
			U_Q1B: begin mul_a = 33'(att2_q); mul_b = 33'(th2_q); end
			U_Q1C: begin mul_a = 33'(att3_q); mul_b = 33'(th1_q); end
			U_Q2A: begin mul_a = 33'(att0_q); mul_b = 33'(th1_q); end
			U_Q2B: begin mul_a = 33'(att1_q); mul_b = 33'(th2_q); end
			U_Q2C: begin mul_a = 33'(att3_q); mul_b = 33'(th0_q); end
			U_Q3A: begin mul_a = 33'(att0_q); mul_b = 33'(th2_q); end
			U_Q3B: begin mul_a = 33'(att1_q); mul_b = 33'(th1_q); end
			U_Q3C: begin mul_a = 33'(att2_q); mul_b = 33'(th0_q); end
			U_N0:  begin mul_a = 33'(qn0_q); mul_b = 33'(qn0_q); end
			U_N1:  begin mul_a = 33'(qn1_q); mul_b = 33'(qn1_q); end
			U_N2:  begin mul_a = 33'(qn2_q); mul_b = 33'(qn2_q); end
			U_N3:  begin mul_a = 33'(qn3_q); mul_b = 33'(qn3_q); end
			U_AT0: begin mul_a = 33'(qn0_q); mul_b = 33'(y_q); end
			U_AT1: begin mul_a = 33'(qn1_q); mul_b = 33'(y_q); end
			U_AT2: begin mul_a = 33'(qn2_q); mul_b = 33'(y_q); end
			U_AT3: begin mul_a = 33'(qn3_q); mul_b = 33'(y_q); end
			default: has_mul = 1'b0;
		endcase
	end

	assign sample_stall = (uop_q != U_IDLE);
	assign cfg_ready    = 1'b1;
	assign quat_valid   = quat_valid_q;
	assign quat_w       = quat_w_q;
	assign quat_x       = quat_x_q;
	assign quat_y       = quat_y_q;
	assign quat_z       = quat_z_q;
	assign accel_trust  = trust_out_q;

	// control, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uop_q             <= U_IDLE;
			ph_q              <= 1'b0;
			it_q              <= '0;
			rs_sel_q          <= 1'b0;
			quat_valid_q      <= 1'b0;
			prop_gain_q       <= PROP_GAIN_RST;
			integral_gain_q   <= INT_GAIN_RST;
			dyn_enable_q      <= 1'b1;
			gravity_ref_q     <= GRAVITY_RST;
			deviation_scale_q <= DEV_SCALE_RST;
			bias_x_q          <= '0;
			bias_y_q          <= '0;
			bias_z_q          <= '0;
			att0_q            <= Q30_ONE;
			att1_q            <= '0;
			att2_q            <= '0;
			att3_q            <= '0;
			ei0_q             <= '0;
			ei1_q             <= '0;
			ei2_q             <= '0;
			trust_q           <= '0;
		end else begin
			ph_q <= has_mul && !adv;
			if (adv)
				uop_q <= uop_nxt;

			if (uop_q == U_DONE && adv)
				quat_valid_q <= 1'b1;
			else if (!quat_stall)
				quat_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_PROP_GAIN:     prop_gain_q       <= cfg_data[23:0];
					CFG_INTEGRAL_GAIN: integral_gain_q   <= cfg_data[23:0];
					CFG_DYN_ENABLE:    dyn_enable_q      <= cfg_data[0];
					CFG_GRAVITY_REF:   gravity_ref_q     <= cfg_data[23:0];
					CFG_DEV_SCALE:     deviation_scale_q <= cfg_data[23:0];
					CFG_BIAS_X:        bias_x_q          <= cfg_data;
					CFG_BIAS_Y:        bias_y_q          <= cfg_data;
					CFG_BIAS_Z:        bias_z_q          <= cfg_data;
					default: ;
				endcase
			end

			if (adv) begin
				unique case (uop_q)
					U_ACHK: rs_sel_q <= 1'b0;
					U_NCHK: begin
						rs_sel_q <= 1'b1;
						if (acc_q[63:0] == 64'd0) begin
							att0_q <= Q30_ONE;
							att1_q <= '0;
							att2_q <= '0;
							att3_q <= '0;
						end
					end
					U_CH: it_q <= '0;
					U_ND: it_q <= it_q + 1'b1;
					U_TRD: trust_q <= (p16 >= 68'sd65536) ? 17'd0 : TRUST_ONE - p16[16:0];
					U_I0: ei0_q <= (integral_gain_q == 24'd0) ? 32'sd0 : sat32(sx32(ei0_q) + p38);
					U_I1: ei1_q <= (integral_gain_q == 24'd0) ? 32'sd0 : sat32(sx32(ei1_q) + p38);
					U_I2: ei2_q <= (integral_gain_q == 24'd0) ? 32'sd0 : sat32(sx32(ei2_q) + p38);
					U_AT0: att0_q <= sat32(ph);
					U_AT1: att1_q <= sat32(ph);
					U_AT2: att2_q <= sat32(ph);
					U_AT3: att3_q <= sat32(ph);
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (adv) begin
			unique case (uop_q)
				U_IDLE: begin
					ax_q <= accel_x;
					ay_q <= accel_y;
					az_q <= accel_z;
					dt_q <= time_step;
					g0_q <= 36'(gyro_x) - 36'(bias_x_q);
					g1_q <= 36'(gyro_y) - 36'(bias_y_q);
					g2_q <= 36'(gyro_z) - 36'(bias_z_q);
				end
				U_ASQ0: acc_q <= prod_x;
				U_ASQ1, U_ASQ2: acc_q <= acc_q + prod_x;
				U_ACHK: begin
					x_q  <= acc_q[63:0];
					k_q  <= '0;
					kp_q <= prop_gain_q;
				end
				U_NORM: begin
					if (x_q[63:56] == 8'd0) begin
						x_q <= {x_q[55:0], 8'd0};
						k_q <= k_q + 5'd4;
					end else if (x_q[63:62] == 2'b00) begin
						x_q <= {x_q[61:0], 2'b00};
						k_q <= k_q + 5'd1;
					end else begin
						m_q <= x_q[63:32];
						h_q <= 5'd31 - k_q;
					end
				end
				U_CH: y_q <= m_q[31] ? CHORD_MID - p30[31:0] : Q30_ONE - p30[31:0];
				U_NY: t_q <= p30[31:0];
				U_NU: d_q <= (p30 >= 68'sd3221225472) ? 32'd0 : 32'hC000_0000 - p30[31:0];
				U_ND: y_q <= p31[31:0];
				U_TRM: dev_q <= dev[31:0];
				U_TRK: kf_q <= KP_FLOOR_Q16 + p16[16:0];
				U_TRP: kp_q <= p16[23:0];
				U_AN0: an0_q <= sat32(ph);
				U_AN1: an1_q <= sat32(ph);
				U_AN2: an2_q <= sat32(ph);
				U_V0A, U_V1A, U_V2A: acc_q <= p30;
				U_V0B: v0_q <= sat32((acc_q - p30) <<< 1);
				U_V1B: v1_q <= sat32((acc_q + p30) <<< 1);
				U_V2B, U_V2C: acc_q <= acc_q - p30;
				U_V2D: v2_q <= sat32(acc_q + p30);
				U_E0A, U_E1A, U_E2A: acc_q <= prod_x;
				U_E0B: e0_q <= sat32((acc_q - prod_x) >>> 30);
				U_E1B: e1_q <= sat32((acc_q - prod_x) >>> 30);
				U_E2B: e2_q <= sat32((acc_q - prod_x) >>> 30);
				U_G0K: g0_q <= g0_q + p30[35:0];
				U_G0I: g0_q <= g0_q + p24[35:0];
				U_G1K: g1_q <= g1_q + p30[35:0];
				U_G1I: g1_q <= g1_q + p24[35:0];
				U_G2K: g2_q <= g2_q + p30[35:0];
				U_G2I: g2_q <= g2_q + p24[35:0];
				U_TH0: th0_q <= sat32(p19);
				U_TH1: th1_q <= sat32(p19);
				U_TH2: th2_q <= sat32(p19);
				U_Q0A: acc_q <= sx32(att0_q) - p30;
				U_Q1A: acc_q <= sx32(att1_q) + p30;
				U_Q2A: acc_q <= sx32(att2_q) + p30;
				U_Q3A: acc_q <= sx32(att3_q) + p30;
				U_Q0B: acc_q <= acc_q - p30;
				U_Q1B: acc_q <= acc_q + p30;
				U_Q2B: acc_q <= acc_q - p30;
				U_Q3B: acc_q <= acc_q + p30;
				U_Q0C: qn0_q <= sat32(acc_q - p30);
				U_Q1C: qn1_q <= sat32(acc_q - p30);
				U_Q2C: qn2_q <= sat32(acc_q + p30);
				U_Q3C: qn3_q <= sat32(acc_q - p30);
				U_N0: acc_q <= prod_x;
				U_N1, U_N2, U_N3: acc_q <= acc_q + prod_x;
				U_NCHK: begin
					x_q <= acc_q[63:0];
					k_q <= '0;
				end
				U_DONE: begin
					quat_w_q    <= att0_q;
					quat_x_q    <= att1_q;
					quat_y_q    <= att2_q;
					quat_z_q    <= att3_q;
					trust_out_q <= trust_q;
				end
				default: ;
			endcase
		end
	end

	// assertions
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> (uop_q == U_ASQ0))
		else $error("accepted beat did not start the sequence");

	a_mantissa_range: assert property (@(posedge clk) disable iff (!arst_n)
		(uop_q == U_CH) |-> (m_q >= Q30_ONE))
		else $error("normalized mantissa below one");

	a_trust_range: assert property (@(posedge clk) disable iff (!arst_n)
		trust_q <= TRUST_ONE)
		else $error("trust above one");

	a_phase_mul: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q |-> has_mul)
		else $error("second phase outside a multiply step");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(uop_q == U_DONE && adv) |=> quat_valid_q)
		else $error("result beat not presented");

endmodule
